[design/tsaf_pkg.sv]
// ----------------------------------------------------------------------------
// tsaf_pkg: shared types for the adaptation field parser
// Parser phase codes and the payload records of the request and response
// channels.
// ----------------------------------------------------------------------------
package tsaf_pkg;

   // Parser phase. The order of the codes matters: the walk through the
   // optional fields compares phases by their position.
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_FLAGS     = 4'd1,
      PH_PCR       = 4'd2,
      PH_OPCR      = 4'd3,
      PH_SPLICE    = 4'd4,
      PH_PRIV_LEN  = 4'd5,
      PH_PRIV_DATA = 4'd6,
      PH_EXT_LEN   = 4'd7,
      PH_STUFF     = 4'd8,
      PH_EXT_FLAGS = 4'd9,
      PH_LTW       = 4'd10,
      PH_PR        = 4'd11,
      PH_SS        = 4'd12,
      PH_EXT_RES   = 4'd13
   } phase_type;

   // Byte counts of the multi-byte sub-fields.
   localparam logic [2:0] PCR_BYTES  = 3'd6;
   localparam logic [2:0] LTW_BYTES  = 3'd2;
   localparam logic [2:0] PR_BYTES   = 3'd3;
   localparam logic [2:0] SS_BYTES   = 3'd5;

   // Flag byte bit positions.
   localparam int FLAG_PCR     = 4;
   localparam int FLAG_OPCR    = 3;
   localparam int FLAG_SPLICE  = 2;
   localparam int FLAG_PRIVATE = 1;
   localparam int FLAG_EXT     = 0;

   // Extension flag bit positions.
   localparam int EXT_LTW = 2;
   localparam int EXT_PR  = 1;
   localparam int EXT_SS  = 0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       field_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  flag_byte;
      logic [2:0]  ext_flags;
      logic [32:0] pcr_base;
      logic [8:0]  pcr_ext;
      logic [32:0] opcr_base;
      logic [8:0]  opcr_ext;
      logic [7:0]  splice_count;
      logic [14:0] legal_window_ofs;
      logic [21:0] pw_rate;
      logic [32:0] next_au_dts;
      logic [7:0]  stuffing_count;
      logic        status;
   } rsp_payload_type;

endpackage

[design/tsaf_channels.sv]
// ----------------------------------------------------------------------------
// tsaf channels: valid/ready interfaces of the adaptation field parser
// One interface for the byte stream in, one for the decoded results out.
// A beat moves at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tsaf_req_if
   import tsaf_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tsaf_rsp_if
   import tsaf_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/ts_adaptation_field_parser_top.sv]
// ----------------------------------------------------------------------------
// ts_adaptation_field_parser_top: MPEG-2 TS adaptation field parser
// The block takes one adaptation field byte per beat, at up to one beat per
// clock, and returns one decoded result beat after the last byte of each
// field (at once for a zero length field). Each byte is decoded by the
// parser state in the same cycle it is taken; the result appears on the
// response channel in the cycle after the field's last byte is accepted. The
// response is held in a single output register, and the request side keeps
// taking bytes while that register is empty or being drained, so a stalled
// response stops the byte stream only while an unread result waits.
// ----------------------------------------------------------------------------
module ts_adaptation_field_parser_top
   import tsaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tsaf_req_if.sink    req_chan,
   tsaf_rsp_if.source  rsp_chan
);

   // Parser state.
   phase_type       phase_ff, phase_in;
   logic [7:0]      field_left_ff, field_left_in;
   logic [7:0]      ext_left_ff, ext_left_in;
   logic [2:0]      sub_idx_ff, sub_idx_in;
   logic [7:0]      priv_left_ff, priv_left_in;
   logic [47:0]     acc_ff, acc_in;
   rsp_payload_type held_ff, held_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   logic            req_accept;
   logic            emit;
   logic            do_outer, do_ext;
   phase_type       outer_stage, ext_stage, nxt;
   logic [7:0]      b;

   // Next optional field after the flag byte, starting the search at stage.
   function automatic phase_type outer_next(input phase_type stage,
                                            input logic [7:0] flags);
      phase_type r;
      r = PH_STUFF;
      if (stage <= PH_PCR && flags[FLAG_PCR])               r = PH_PCR;
      else if (stage <= PH_OPCR && flags[FLAG_OPCR])        r = PH_OPCR;
      else if (stage <= PH_SPLICE && flags[FLAG_SPLICE])    r = PH_SPLICE;
      else if (stage <= PH_PRIV_LEN && flags[FLAG_PRIVATE]) r = PH_PRIV_LEN;
      else if (stage <= PH_EXT_LEN && flags[FLAG_EXT])      r = PH_EXT_LEN;
      return r;
   endfunction

   // Next extension sub-field; idle means none is left.
   function automatic phase_type ext_next(input phase_type stage,
                                          input logic [2:0] flags);
      phase_type r;
      r = PH_IDLE;
      if (stage <= PH_LTW && flags[EXT_LTW])     r = PH_LTW;
      else if (stage <= PH_PR && flags[EXT_PR])  r = PH_PR;
      else if (stage <= PH_SS && flags[EXT_SS])  r = PH_SS;
      return r;
   endfunction

   // Handshake: take a byte while the output register is free or draining.
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign b              = req_chan.payload.data_byte;

   // Decode of one byte against the current parser state.
   always_comb begin
      phase_in      = phase_ff;
      field_left_in = field_left_ff;
      ext_left_in   = ext_left_ff;
      sub_idx_in    = sub_idx_ff;
      priv_left_in  = priv_left_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      emit          = 1'b0;
      do_outer      = 1'b0;
      do_ext        = 1'b0;
      outer_stage   = PH_IDLE;
      ext_stage     = PH_IDLE;
      nxt           = PH_IDLE;
      if (req_accept) begin
         if (req_chan.payload.field_start) begin
            // Length byte: restart with a cleared record.
            phase_in      = PH_IDLE;
            field_left_in = '0;
            ext_left_in   = '0;
            sub_idx_in    = '0;
            priv_left_in  = '0;
            acc_in        = '0;
            held_in       = '0;
            if (b == 8'd0) begin
               emit = 1'b1;
            end else begin
               field_left_in = b;
               phase_in      = PH_FLAGS;
            end
         end else if (phase_ff == PH_IDLE || field_left_ff == 8'd0) begin
            phase_in = PH_IDLE;
         end else begin
            field_left_in = field_left_ff - 8'd1;
            if (phase_ff >= PH_EXT_FLAGS && ext_left_ff != 8'd0) begin
               ext_left_in = ext_left_ff - 8'd1;
            end
            case (phase_ff)
               PH_FLAGS: begin
                  held_in.flag_byte = b;
                  do_outer    = 1'b1;
                  outer_stage = PH_PCR;
               end
               PH_PCR, PH_OPCR: begin
                  acc_in     = {acc_ff[39:0], b};
                  sub_idx_in = sub_idx_ff + 3'd1;
                  if (sub_idx_in >= PCR_BYTES) begin
                     if (phase_ff == PH_PCR) begin
                        held_in.pcr_base = acc_in[47:15];
                        held_in.pcr_ext  = acc_in[8:0];
                        outer_stage      = PH_OPCR;
                     end else begin
                        held_in.opcr_base = acc_in[47:15];
                        held_in.opcr_ext  = acc_in[8:0];
                        outer_stage       = PH_SPLICE;
                     end
                     do_outer = 1'b1;
                  end
               end
               PH_SPLICE: begin
                  held_in.splice_count = b;
                  do_outer    = 1'b1;
                  outer_stage = PH_PRIV_LEN;
               end
               PH_PRIV_LEN: begin
                  priv_left_in = b;
                  if (b == 8'd0) begin
                     do_outer    = 1'b1;
                     outer_stage = PH_EXT_LEN;
                  end else begin
                     phase_in = PH_PRIV_DATA;
                  end
               end
               PH_PRIV_DATA: begin
                  if (priv_left_ff != 8'd0) begin
                     priv_left_in = priv_left_ff - 8'd1;
                  end
                  if (priv_left_in == 8'd0) begin
                     do_outer    = 1'b1;
                     outer_stage = PH_EXT_LEN;
                  end
               end
               PH_EXT_LEN: begin
                  ext_left_in = b;
                  if (b == 8'd0) begin
                     do_outer    = 1'b1;
                     outer_stage = PH_STUFF;
                  end else begin
                     phase_in = PH_EXT_FLAGS;
                  end
               end
               PH_EXT_FLAGS: begin
                  held_in.ext_flags = b[7:5];
                  do_ext    = 1'b1;
                  ext_stage = PH_LTW;
               end
               PH_LTW: begin
                  acc_in     = {acc_ff[39:0], b};
                  sub_idx_in = sub_idx_ff + 3'd1;
                  if (sub_idx_in >= LTW_BYTES) begin
                     held_in.legal_window_ofs = acc_in[14:0];
                     do_ext    = 1'b1;
                     ext_stage = PH_PR;
                  end else if (ext_left_in == 8'd0) begin
                     held_in.status = 1'b1;
                     do_outer    = 1'b1;
                     outer_stage = PH_STUFF;
                  end
               end
               PH_PR: begin
                  acc_in     = {acc_ff[39:0], b};
                  sub_idx_in = sub_idx_ff + 3'd1;
                  if (sub_idx_in >= PR_BYTES) begin
                     held_in.pw_rate = acc_in[21:0];
                     do_ext    = 1'b1;
                     ext_stage = PH_SS;
                  end else if (ext_left_in == 8'd0) begin
                     held_in.status = 1'b1;
                     do_outer    = 1'b1;
                     outer_stage = PH_STUFF;
                  end
               end
               PH_SS: begin
                  acc_in     = {acc_ff[39:0], b};
                  sub_idx_in = sub_idx_ff + 3'd1;
                  if (sub_idx_in >= SS_BYTES) begin
                     // DTS parts sit between marker bits.
                     held_in.next_au_dts = {acc_in[35:33], acc_in[31:17], acc_in[15:1]};
                     do_ext    = 1'b1;
                     ext_stage = PH_EXT_RES;
                  end else if (ext_left_in == 8'd0) begin
                     held_in.status = 1'b1;
                     do_outer    = 1'b1;
                     outer_stage = PH_STUFF;
                  end
               end
               PH_EXT_RES: begin
                  if (ext_left_in == 8'd0) begin
                     do_outer    = 1'b1;
                     outer_stage = PH_STUFF;
                  end
               end
               default: begin
               end
            endcase

            // Step to the next extension sub-field, or leave the extension.
            if (do_ext) begin
               nxt = ext_next(ext_stage, held_in.ext_flags);
               if (nxt != PH_IDLE) begin
                  if (ext_left_in == 8'd0) begin
                     held_in.status = 1'b1;
                     do_outer    = 1'b1;
                     outer_stage = PH_STUFF;
                  end else begin
                     phase_in   = nxt;
                     sub_idx_in = '0;
                     acc_in     = '0;
                  end
               end else if (ext_left_in != 8'd0) begin
                  phase_in = PH_EXT_RES;
               end else begin
                  do_outer    = 1'b1;
                  outer_stage = PH_STUFF;
               end
            end

            // Step to the next optional field, or into the stuffing.
            if (do_outer) begin
               phase_in = outer_next(outer_stage, held_in.flag_byte);
               if (phase_in == PH_STUFF) begin
                  held_in.stuffing_count = field_left_in;
               end else begin
                  sub_idx_in = '0;
                  acc_in     = '0;
               end
            end

            // Last byte of the field: anything unfinished is an overrun.
            if (field_left_in == 8'd0) begin
               if (phase_in != PH_STUFF) begin
                  held_in.status = 1'b1;
               end
               emit     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
      end
   end

   // Output register valid: set by a new result, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         field_left_ff <= '0;
         ext_left_ff   <= '0;
         sub_idx_ff    <= '0;
         priv_left_ff  <= '0;
         acc_ff        <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         field_left_ff <= field_left_in;
         ext_left_ff   <= ext_left_in;
         sub_idx_ff    <= sub_idx_in;
         priv_left_ff  <= priv_left_in;
         acc_ff        <= acc_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= held_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

[design/tsaf_checker.sv]
// ----------------------------------------------------------------------------
// tsaf_checker: port-level assertions for the adaptation field parser
// Watches the request and response channels of the top level and is bound
// to it below.
// ----------------------------------------------------------------------------
module tsaf_checker
   import tsaf_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // A stalled response beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // A zero length byte yields an all-zero result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.field_start && req_payload.data_byte == 8'd0
      |=> rsp_valid && rsp_payload == '0)
      else $error("zero length field did not give an empty result");

   // A nonzero length byte starts a field and gives no result yet.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.field_start && req_payload.data_byte != 8'd0
      |=> !rsp_valid)
      else $error("result appeared on a field start");

   // A new result only follows an accepted byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted byte");

endmodule

bind ts_adaptation_field_parser_top tsaf_checker u_tsaf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_payload (req_chan.payload),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the TS adaptation field parser
// Feeds adaptation field byte streams into the parser, predicts each decoded
// result with an independent behavioral decoder, and compares every result
// beat field by field. Directed fields cover the corner cases. Random fields,
// mostly well formed with random content, follow with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
   import tsaf_pkg::*;

   localparam int TARGET_BEATS = 1150;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      req_payload_type beat;
      logic            drain;
   } pending_beat_type;

   logic clock = 1'b0;
   logic reset;

   tsaf_req_if req_if ();
   tsaf_rsp_if rsp_if ();

   ts_adaptation_field_parser_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pending_beat_type byte_queue[$];
   rsp_payload_type  awaited_results[$];
   int               counted_beats = 0;
   logic             drain_next = 1'b0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               send_gap = 0;
   int               recv_gap = 0;
   int               calm_left = 0;
   logic             req_fire = 1'b0;
   logic             rsp_fire = 1'b0;

   // Decoder state, kept in step with the parser.
   phase_type       walk_phase = PH_IDLE;
   logic [7:0]      bytes_left = '0;
   logic [7:0]      ext_bytes_left = '0;
   logic [7:0]      priv_bytes_left = '0;
   logic [2:0]      sub_count = '0;
   logic [47:0]     shift_reg = '0;
   rsp_payload_type building = '0;

   // Start a multi-byte sub-field or a length byte.
   function automatic void open_sub(input phase_type ph);
      walk_phase = ph;
      sub_count  = '0;
      shift_reg  = '0;
   endfunction

   // Move to the next optional field that the flag byte announces.
   function automatic void next_outer(input phase_type from);
      if (from <= PH_PCR && building.flag_byte[FLAG_PCR]) begin
         open_sub(PH_PCR);
      end else if (from <= PH_OPCR && building.flag_byte[FLAG_OPCR]) begin
         open_sub(PH_OPCR);
      end else if (from <= PH_SPLICE && building.flag_byte[FLAG_SPLICE]) begin
         open_sub(PH_SPLICE);
      end else if (from <= PH_PRIV_LEN && building.flag_byte[FLAG_PRIVATE]) begin
         open_sub(PH_PRIV_LEN);
      end else if (from <= PH_EXT_LEN && building.flag_byte[FLAG_EXT]) begin
         open_sub(PH_EXT_LEN);
      end else begin
         walk_phase              = PH_STUFF;
         building.stuffing_count = bytes_left;
      end
   endfunction

   // Move to the next extension sub-field, or past the extension.
   function automatic void next_ext(input phase_type from);
      phase_type nxt;
      nxt = PH_IDLE;
      if (from <= PH_LTW && building.ext_flags[EXT_LTW]) nxt = PH_LTW;
      else if (from <= PH_PR && building.ext_flags[EXT_PR]) nxt = PH_PR;
      else if (from <= PH_SS && building.ext_flags[EXT_SS]) nxt = PH_SS;
      if (nxt != PH_IDLE) begin
         if (ext_bytes_left == 0) begin
            building.status = 1'b1;
            next_outer(PH_STUFF);
         end else begin
            open_sub(nxt);
         end
      end else if (ext_bytes_left > 0) begin
         walk_phase = PH_EXT_RES;
      end else begin
         next_outer(PH_STUFF);
      end
   endfunction

   // Shift one byte into a sub-field; true on its last byte.
   function automatic logic shift_in(input logic [7:0] b, input logic [2:0] nbytes);
      shift_reg = {shift_reg[39:0], b};
      sub_count = sub_count + 3'd1;
      return sub_count >= nbytes;
   endfunction

   // Decode one accepted byte; returns 1 when it completes a field.
   function automatic logic decode_byte(input req_payload_type beat,
                                        output rsp_payload_type res);
      logic [7:0]  b;
      logic [47:0] a;
      logic [2:0]  nbytes;
      b   = beat.data_byte;
      res = '0;
      if (beat.field_start) begin
         walk_phase      = PH_IDLE;
         bytes_left      = '0;
         ext_bytes_left  = '0;
         priv_bytes_left = '0;
         sub_count       = '0;
         shift_reg       = '0;
         building        = '0;
         if (b == 8'd0) begin
            res = building;
            return 1'b1;
         end
         bytes_left = b;
         walk_phase = PH_FLAGS;
         return 1'b0;
      end
      if (walk_phase == PH_IDLE || bytes_left == 0) begin
         walk_phase = PH_IDLE;
         return 1'b0;
      end
      bytes_left = bytes_left - 8'd1;
      if (walk_phase >= PH_EXT_FLAGS && ext_bytes_left > 0)
         ext_bytes_left = ext_bytes_left - 8'd1;

      case (walk_phase)
         PH_FLAGS: begin
            building.flag_byte = b;
            next_outer(PH_PCR);
         end
         PH_PCR, PH_OPCR: begin
            if (shift_in(b, PCR_BYTES)) begin
               a = shift_reg;
               if (walk_phase == PH_PCR) begin
                  building.pcr_base = a[47:15];
                  building.pcr_ext  = a[8:0];
                  next_outer(PH_OPCR);
               end else begin
                  building.opcr_base = a[47:15];
                  building.opcr_ext  = a[8:0];
                  next_outer(PH_SPLICE);
               end
            end
         end
         PH_SPLICE: begin
            building.splice_count = b;
            next_outer(PH_PRIV_LEN);
         end
         PH_PRIV_LEN: begin
            priv_bytes_left = b;
            if (b == 8'd0) next_outer(PH_EXT_LEN);
            else walk_phase = PH_PRIV_DATA;
         end
         PH_PRIV_DATA: begin
            if (priv_bytes_left > 0) priv_bytes_left = priv_bytes_left - 8'd1;
            if (priv_bytes_left == 0) next_outer(PH_EXT_LEN);
         end
         PH_EXT_LEN: begin
            ext_bytes_left = b;
            if (b == 8'd0) next_outer(PH_STUFF);
            else walk_phase = PH_EXT_FLAGS;
         end
         PH_EXT_FLAGS: begin
            building.ext_flags = b[7:5];
            next_ext(PH_LTW);
         end
         PH_LTW, PH_PR, PH_SS: begin
            if (walk_phase == PH_LTW) nbytes = LTW_BYTES;
            else if (walk_phase == PH_PR) nbytes = PR_BYTES;
            else nbytes = SS_BYTES;
            if (shift_in(b, nbytes)) begin
               a = shift_reg;
               if (walk_phase == PH_LTW) begin
                  building.legal_window_ofs = a[14:0];
                  next_ext(PH_PR);
               end else if (walk_phase == PH_PR) begin
                  building.pw_rate = a[21:0];
                  next_ext(PH_SS);
               end else begin
                  // Marker bits between the three DTS parts are dropped.
                  building.next_au_dts = {a[35:33], a[31:17], a[15:1]};
                  next_ext(PH_EXT_RES);
               end
            end else if (ext_bytes_left == 0) begin
               building.status = 1'b1;
               next_outer(PH_STUFF);
            end
         end
         PH_EXT_RES: begin
            if (ext_bytes_left == 0) next_outer(PH_STUFF);
         end
         default: ;
      endcase

      // Last byte of the field: anything unfinished is an overrun.
      if (bytes_left == 0) begin
         if (walk_phase != PH_STUFF) building.status = 1'b1;
         res        = building;
         walk_phase = PH_IDLE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Append one byte to the stimulus queue.
   task automatic queue_byte(input logic [7:0] b, input logic start, input logic counts);
      pending_beat_type item;
      item.beat.data_byte   = b;
      item.beat.field_start = start;
      item.drain            = drain_next;
      drain_next            = 1'b0;
      byte_queue.push_back(item);
      if (counts) counted_beats++;
   endtask

   // Build one adaptation field with random content. The field length is
   // shortened by cut bytes, and shortfall bytes are never sent.
   task automatic queue_field(input logic [7:0] flags, input int priv_len,
                              input logic [2:0] ext_fl, input int ext_trim,
                              input int ext_res, input int stuffing,
                              input int cut, input int shortfall);
      logic [7:0] body[$];
      logic [7:0] ext_body[$];
      int         ext_len;
      int         field_len;
      int         sent;
      body.push_back(flags);
      if (flags[FLAG_PCR]) repeat (6) body.push_back(8'($urandom_range(0, 255)));
      if (flags[FLAG_OPCR]) repeat (6) body.push_back(8'($urandom_range(0, 255)));
      if (flags[FLAG_SPLICE]) body.push_back(8'($urandom_range(0, 255)));
      if (flags[FLAG_PRIVATE]) begin
         body.push_back(8'(priv_len));
         repeat (priv_len) body.push_back(8'($urandom_range(0, 255)));
      end
      if (flags[FLAG_EXT]) begin
         ext_body.push_back({ext_fl, 5'($urandom_range(0, 31))});
         if (ext_fl[EXT_LTW]) repeat (2) ext_body.push_back(8'($urandom_range(0, 255)));
         if (ext_fl[EXT_PR]) repeat (3) ext_body.push_back(8'($urandom_range(0, 255)));
         if (ext_fl[EXT_SS]) repeat (5) ext_body.push_back(8'($urandom_range(0, 255)));
         repeat (ext_res) ext_body.push_back(8'($urandom_range(0, 255)));
         ext_len = ext_body.size() - ext_trim;
         if (ext_len < 0) ext_len = 0;
         body.push_back(8'(ext_len));
         if (ext_len > 0) foreach (ext_body[i]) body.push_back(ext_body[i]);
      end
      repeat (stuffing) body.push_back(8'($urandom_range(0, 255)));

      field_len = body.size() - cut;
      if (field_len < 0) field_len = 0;
      if (field_len > 255) field_len = 255;
      sent = field_len - shortfall;
      if (sent < 0) sent = 0;
      queue_byte(8'(field_len), 1'b1, 1'b1);
      for (int i = 0; i < sent; i++) queue_byte(body[i], 1'b0, 1'b1);
   endtask

   // Report one field of a result beat against its prediction.
   task automatic check_field(input string name, input logic [32:0] want,
                              input logic [32:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Monitor: predict on every accepted byte beat, check every result beat.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         rsp_fire <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            if (decode_byte(req_if.payload, want)) awaited_results.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (awaited_results.size() == 0) begin
               $display("%0t: result beat with nothing awaited, expected none, actual %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("flag_byte", 33'(want.flag_byte), 33'(got.flag_byte));
               check_field("ext_flags", 33'(want.ext_flags), 33'(got.ext_flags));
               check_field("pcr_base", want.pcr_base, got.pcr_base);
               check_field("pcr_ext", 33'(want.pcr_ext), 33'(got.pcr_ext));
               check_field("opcr_base", want.opcr_base, got.opcr_base);
               check_field("opcr_ext", 33'(want.opcr_ext), 33'(got.opcr_ext));
               check_field("splice_count", 33'(want.splice_count),
                           33'(got.splice_count));
               check_field("legal_window_ofs", 33'(want.legal_window_ofs),
                           33'(got.legal_window_ofs));
               check_field("pw_rate", 33'(want.pw_rate), 33'(got.pw_rate));
               check_field("next_au_dts", want.next_au_dts, got.next_au_dts);
               check_field("stuffing_count", 33'(want.stuffing_count),
                           33'(got.stuffing_count));
               check_field("status", 33'(want.status), 33'(got.status));
            end
         end
      end
   end

   // Byte driver: presents queued beats with a random gap before each.
   always @(negedge clock) begin
      logic             more;
      pending_beat_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         more = req_if.valid && !req_fire;
         if (!more) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (byte_queue.size() > 0 &&
                         !(byte_queue[0].drain && awaited_results.size() > 0)) begin
               nxt = byte_queue.pop_front();
               req_if.payload <= nxt.beat;
               more = 1'b1;
               send_gap = (calm_left > 0) ? 0 : $urandom_range(0, 9);
               // Now and then run a stretch with no idling on either side.
               if (calm_left > 0) calm_left--;
               else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 80);
            end
         end
         req_if.valid <= more;
      end
   end

   // Result receiver: holds ready low for a random gap after each beat.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_fire) recv_gap = (calm_left > 0) ? 0 : $urandom_range(0, 9);
         else if (recv_gap > 0) recv_gap--;
         rsp_if.ready <= (recv_gap == 0);
      end
   end

   // Stimulus and end of run.
   initial begin
      int pick;
      int priv_len;
      int ext_trim;
      int stuffing;
      int cut;
      int shortfall;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;

      // Zero length field, then a byte outside any field.
      queue_byte(8'd0, 1'b1, 1'b1);
      queue_byte(8'hA5, 1'b0, 1'b0);
      // Field ends inside the PCR.
      queue_field(8'h10, 0, 3'b000, 0, 0, 0, 4, 0);
      // Field abandoned by a restart.
      queue_field(8'h00, 0, 3'b000, 0, 0, 5, 0, 3);
      // Zero extension length followed by stuffing.
      queue_field(8'h01, 0, 3'b000, 255, 0, 2, 0, 0);
      // LTW cut off by the extension length.
      queue_field(8'h01, 0, 3'b100, 1, 0, 0, 0, 0);

      // Random part: mostly well formed fields, some noise and broken ones.
      drain_next = 1'b1;
      while (counted_beats < TARGET_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end else if (pick < 9) begin
            queue_byte(8'd0, 1'b1, 1'b1);
         end else begin
            pick = $urandom_range(0, 99);
            priv_len = (pick < 70) ? $urandom_range(0, 3) :
                       (pick < 96) ? $urandom_range(4, 20) : $urandom_range(100, 255);
            pick = $urandom_range(0, 99);
            ext_trim = (pick < 80) ? 0 : (pick < 90) ? $urandom_range(1, 4) : 255;
            pick = $urandom_range(0, 99);
            stuffing = (pick < 92) ? $urandom_range(0, 6) : $urandom_range(100, 254);
            cut = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 8);
            shortfall = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 4) : 0;
            queue_field(8'($urandom_range(0, 255)), priv_len, 3'($urandom_range(0, 7)),
                        ext_trim, $urandom_range(0, 3), stuffing, cut, shortfall);
         end
         if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() > 0 || req_if.valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
